### rtl/postfix_expression_evaluator_assert.svh
// Assertion macros for the postfix evaluator. Each use sits on a line of its own.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PFX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pfx_eval_pkg.sv
// ----------------------------------------------------------------------------
// pfx_eval_pkg
// Types, symbol codes and status codes shared by the postfix evaluator.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned DivSteps   = DataW;

  localparam logic [7:0] SymZero = 8'd48;
  localparam logic [7:0] SymNine = 8'd57;
  localparam logic [7:0] SymAdd  = 8'h2B;
  localparam logic [7:0] SymSub  = 8'h2D;
  localparam logic [7:0] SymMul  = 8'h2A;
  localparam logic [7:0] SymDiv  = 8'h2F;
  localparam logic [7:0] SymMod  = 8'h25;
  localparam logic [7:0] SymPow  = 8'h5E;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusUnderflow = 3'd1,
    StatusOverflow  = 3'd2,
    StatusDivZero   = 3'd3,
    StatusUnknown   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StDecode,
    StReadLeft,
    StLatchLeft,
    StExec,
    StPow,
    StDiv,
    StDivFix,
    StWrite,
    StFinish,
    StEmit
  } state_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_item_t;

endpackage

### rtl/pfx_eval_ram.sv
// ----------------------------------------------------------------------------
// pfx_eval_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfx_eval_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/postfix_expression_evaluator.sv
// Per transaction: / and % run the serial divider unless the divisor is zero;
// ^ squares the base once per exponent bit up to the highest set bit, or skips
// that loop for a negative exponent. A last symbol also waits for the output
// register. The divider produces one quotient bit per cycle.
// Reset clears the stack pointer, sticky status and output valid; the stack
// RAM is not cleared, since no entry above the stack pointer is ever read.
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Stack-based postfix evaluator with a shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_assert.svh"

module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = pfx_eval_pkg::StackDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pfx_eval_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pfx_eval_pkg::out_item_t out_item_o
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW    = pfx_eval_pkg::DataW;
  localparam int unsigned CntW  = $clog2(pfx_eval_pkg::DivSteps);

  pfx_eval_pkg::state_e  state_q, state_d;
  pfx_eval_pkg::status_e err_q, err_d;
  logic [SpW-1:0]        sp_q, sp_d;
  logic                  out_valid_q, out_valid_d;
  pfx_eval_pkg::out_item_t out_q, out_d;

  logic [7:0]      sym_q, sym_d;
  logic            last_q, last_d;
  logic [DW-1:0]   l_q, l_d;
  logic [DW-1:0]   r_q, r_d;
  logic [DW-1:0]   res_q, res_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            phase_q, phase_d;
  logic            neg_q, neg_d;

  logic                  set_err;
  pfx_eval_pkg::status_e err_code;

  logic [SpW-1:0]   sp_m1, sp_m2;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0]    ram_wdata, ram_rdata;

  logic [DW-1:0] mul_a, mul_b, prod;
  logic [DW:0]   trial;
  logic [DW-1:0] div_mag;
  logic          is_div;
  logic          out_load;

  assign sp_m1  = sp_q - SpW'(1);
  assign sp_m2  = sp_q - SpW'(2);
  assign is_div = (sym_q == pfx_eval_pkg::SymDiv);

  // Shared multiplier: operands picked by the sequencer.
  always_comb begin
    mul_a = l_q;
    mul_b = l_q;
    if (state_q == pfx_eval_pkg::StExec) begin
      mul_b = r_q;
    end else if (state_q == pfx_eval_pkg::StPow && !phase_q) begin
      mul_a = res_q;
    end
  end
  assign prod = mul_a * mul_b;

  // Restoring division step: dividend shifts out of l_q, quotient shifts in.
  assign trial   = {rem_q, l_q[DW-1]} - {1'b0, r_q};
  assign div_mag = is_div ? l_q : rem_q;

  assign out_load = (state_q == pfx_eval_pkg::StEmit) && (!out_valid_q || out_ready_i);

  pfx_eval_ram #(
    .Width (DW),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sym_d       = sym_q;
    last_d      = last_q;
    l_d         = l_q;
    r_d         = r_q;
    res_d       = res_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    set_err     = 1'b0;
    err_code    = pfx_eval_pkg::StatusOk;
    ram_we      = 1'b0;
    ram_waddr   = sp_q[AddrW-1:0];
    ram_wdata   = DW'(sym_q - pfx_eval_pkg::SymZero);
    ram_raddr   = sp_m1[AddrW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pfx_eval_pkg::StIdle: begin
        if (in_valid_i) begin
          sym_d   = in_item_i.symbol;
          last_d  = in_item_i.last_symbol;
          state_d = pfx_eval_pkg::StDecode;
        end
      end
      pfx_eval_pkg::StDecode: begin
        state_d = pfx_eval_pkg::StFinish;
        if (sym_q inside {[pfx_eval_pkg::SymZero:pfx_eval_pkg::SymNine]}) begin
          if (sp_q >= SpW'(STACK_DEPTH)) begin
            set_err  = 1'b1;
            err_code = pfx_eval_pkg::StatusOverflow;
          end else begin
            ram_we = 1'b1;
            sp_d   = sp_q + SpW'(1);
          end
        end else if (sym_q inside {pfx_eval_pkg::SymAdd, pfx_eval_pkg::SymSub,
                                   pfx_eval_pkg::SymMul, pfx_eval_pkg::SymDiv,
                                   pfx_eval_pkg::SymMod, pfx_eval_pkg::SymPow}) begin
          if (sp_q < SpW'(2)) begin
            set_err  = 1'b1;
            err_code = pfx_eval_pkg::StatusUnderflow;
          end else begin
            // Right operand read issued here.
            state_d = pfx_eval_pkg::StReadLeft;
          end
        end else begin
          set_err  = 1'b1;
          err_code = pfx_eval_pkg::StatusUnknown;
        end
      end
      pfx_eval_pkg::StReadLeft: begin
        r_d       = ram_rdata;
        ram_raddr = sp_m2[AddrW-1:0];
        state_d   = pfx_eval_pkg::StLatchLeft;
      end
      pfx_eval_pkg::StLatchLeft: begin
        l_d     = ram_rdata;
        state_d = pfx_eval_pkg::StExec;
      end
      pfx_eval_pkg::StExec: begin
        state_d = pfx_eval_pkg::StWrite;
        case (sym_q)
          pfx_eval_pkg::SymAdd: res_d = l_q + r_q;
          pfx_eval_pkg::SymSub: res_d = l_q - r_q;
          pfx_eval_pkg::SymMul: res_d = prod;
          pfx_eval_pkg::SymPow: begin
            if (r_q[DW-1]) begin
              if (l_q == DW'(1)) begin
                res_d = DW'(1);
              end else if (l_q == {DW{1'b1}}) begin
                res_d = r_q[0] ? {DW{1'b1}} : DW'(1);
              end else begin
                res_d = '0;
              end
            end else begin
              res_d   = DW'(1);
              phase_d = 1'b0;
              state_d = pfx_eval_pkg::StPow;
            end
          end
          default: begin
            // Divide or remainder.
            if (r_q == '0) begin
              set_err  = 1'b1;
              err_code = pfx_eval_pkg::StatusDivZero;
              res_d    = '0;
            end else begin
              l_d     = l_q[DW-1] ? (DW'(0) - l_q) : l_q;
              r_d     = r_q[DW-1] ? (DW'(0) - r_q) : r_q;
              neg_d   = is_div ? (l_q[DW-1] ^ r_q[DW-1]) : l_q[DW-1];
              rem_d   = '0;
              cnt_d   = '0;
              state_d = pfx_eval_pkg::StDiv;
            end
          end
        endcase
      end
      pfx_eval_pkg::StPow: begin
        // Alternate: multiply into the accumulator, then square the base.
        if (r_q == '0) begin
          state_d = pfx_eval_pkg::StWrite;
        end else if (!phase_q) begin
          if (r_q[0]) begin
            res_d = prod;
          end
          phase_d = 1'b1;
        end else begin
          l_d     = prod;
          r_d     = r_q >> 1;
          phase_d = 1'b0;
        end
      end
      pfx_eval_pkg::StDiv: begin
        if (!trial[DW]) begin
          rem_d = trial[DW-1:0];
          l_d   = {l_q[DW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DW-2:0], l_q[DW-1]};
          l_d   = {l_q[DW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(pfx_eval_pkg::DivSteps - 1)) begin
          state_d = pfx_eval_pkg::StDivFix;
        end
      end
      pfx_eval_pkg::StDivFix: begin
        res_d   = neg_q ? (DW'(0) - div_mag) : div_mag;
        state_d = pfx_eval_pkg::StWrite;
      end
      pfx_eval_pkg::StWrite: begin
        ram_we    = 1'b1;
        ram_waddr = sp_m2[AddrW-1:0];
        ram_wdata = res_q;
        sp_d      = sp_m1;
        state_d   = pfx_eval_pkg::StFinish;
      end
      pfx_eval_pkg::StFinish: begin
        // Top-of-stack read issued here for the result.
        state_d = last_q ? pfx_eval_pkg::StEmit : pfx_eval_pkg::StIdle;
      end
      pfx_eval_pkg::StEmit: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_d.value  = (sp_q != '0) ? ram_rdata : '0;
          out_d.status = err_q;
          sp_d         = '0;
          state_d      = pfx_eval_pkg::StIdle;
        end
      end
      default: begin
        state_d = pfx_eval_pkg::StIdle;
      end
    endcase

    err_d = err_q;
    if (out_load) begin
      err_d = pfx_eval_pkg::StatusOk;
    end else if (set_err && err_q == pfx_eval_pkg::StatusOk) begin
      err_d = err_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfx_eval_pkg::StIdle;
      err_q       <= pfx_eval_pkg::StatusOk;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    sym_q   <= sym_d;
    last_q  <= last_d;
    l_q     <= l_d;
    r_q     <= r_d;
    res_q   <= res_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    phase_q <= phase_d;
    neg_q   <= neg_d;
  end

  assign in_ready_o  = (state_q == pfx_eval_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PFX_ASSERT_IMPL(a_sp_bound, clk_i, rst_ni, 1'b1, sp_q <= SpW'(STACK_DEPTH), "stack pointer past depth")
  `PFX_ASSERT_IMPL(a_write_depth, clk_i, rst_ni, state_q == pfx_eval_pkg::StWrite, sp_q >= SpW'(2), "result write without two operands")
  `PFX_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, state_q == pfx_eval_pkg::StDiv, r_q != '0, "divider running on zero divisor")
  `PFX_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, out_load, (sp_q == '0) && (err_q == pfx_eval_pkg::StatusOk) && out_valid_q, "result load did not clear the stack")

endmodule
